// ----- rtl/srctok_pkg.sv -----
`timescale 1ns / 1ps

package srctok_pkg;

    localparam int SPACE_DEPTH = 16;
    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;
    localparam int SPC_CNT_W   = $clog2(SPACE_DEPTH + 1);
    localparam int SPC_IDX_W   = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_LINE_W  = 24;
    localparam int OUT_COL_W   = 16;
    localparam int ERR_CNT_W   = 9;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic CFG_MAX_ERRORS = 1'b0;
    localparam logic CFG_TAB_WIDTH  = 1'b1;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_IDENT      = 4'd1,
        MODE_NUMBER     = 4'd2,
        MODE_LINE_CMT   = 4'd3,
        MODE_BLOCK_CMT  = 4'd4,
        MODE_DIR_NAME   = 4'd5,
        MODE_DIR_LEAD   = 4'd6,
        MODE_DIR_PARAM  = 4'd7,
        MODE_DIR_BSLASH = 4'd8,
        MODE_DIR_CONT   = 4'd9
    } t_mode;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_NUMBER = 3'd1,
        KIND_SINGLE = 3'd2,
        KIND_MARK   = 3'd3,
        KIND_NAME   = 3'd4,
        KIND_PARAM  = 3'd5,
        KIND_END    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        SPC_NONE  = 2'd0,
        SPC_PUSH  = 2'd1,
        SPC_FLUSH = 2'd2,
        SPC_CLEAR = 2'd3
    } t_spc_op;

    typedef enum logic [1:0] {
        PH_SLASH = 2'd0,
        PH_BUF   = 2'd1,
        PH_MAIN  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
    } t_pos;

    typedef struct packed {
        logic       slash;
        t_pos       hpos;
        t_spc_op    spc_op;
        logic [7:0] spc_byte;
        logic       main_vld;
        logic [7:0] main_byte;
        t_kind      main_kind;
        logic       main_first;
        logic       main_err;
        t_pos       mpos;
        logic       fatal;
    } t_cmd;

endpackage

// ----- rtl/srctok_fifo.sv -----
`timescale 1ns / 1ps

module srctok_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  srctok_pkg::t_cmd                i_cmd,
    input  logic                            i_pop,
    output srctok_pkg::t_cmd                o_cmd,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [srctok_pkg::Q_CNT_W-1:0]  o_count
);

    srctok_pkg::t_cmd r_mem [srctok_pkg::QUEUE_DEPTH];
    logic [srctok_pkg::Q_IDX_W-1:0] r_rd;
    logic [srctok_pkg::Q_IDX_W-1:0] r_wr;
    logic [srctok_pkg::Q_CNT_W-1:0] r_cnt;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == srctok_pkg::Q_CNT_W'(srctok_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == srctok_pkg::Q_IDX_W'(srctok_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == srctok_pkg::Q_IDX_W'(srctok_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/srctok_front.sv -----
`timescale 1ns / 1ps

module srctok_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  logic             i_full,
    output logic             o_push,
    output srctok_pkg::t_cmd o_cmd
);

    localparam logic [srctok_pkg::ERR_CNT_W-1:0] ERR_MAX = '1;
    localparam logic [srctok_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [srctok_pkg::COLUMN_BITS-1:0] COL_MAX = '1;

    logic [7:0]                        r_max_err;
    logic [4:0]                        r_tab;
    srctok_pkg::t_mode                 r_mode, n_mode;
    logic                              r_slash, n_slash;
    logic                              r_star, n_star;
    logic [srctok_pkg::LINE_BITS-1:0]  r_line, n_line;
    logic [srctok_pkg::COLUMN_BITS-1:0] r_col, n_col;
    srctok_pkg::t_pos                  r_held, n_held;
    logic [srctok_pkg::ERR_CNT_W-1:0]  r_err, n_err;
    logic                              r_fatal, n_fatal;
    srctok_pkg::t_cmd                  cmd;
    logic                              accept;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction
    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction
    function automatic logic is_white(input logic [7:0] b);
        return b == srctok_pkg::CH_SP || b == srctok_pkg::CH_TAB ||
               b == srctok_pkg::CH_CR || b == srctok_pkg::CH_NL;
    endfunction
    function automatic logic ident_first(input logic [7:0] b);
        return is_letter(b) || b == srctok_pkg::CH_UNDER;
    endfunction
    function automatic logic ident_next(input logic [7:0] b);
        return ident_first(b) || is_digit(b);
    endfunction
    function automatic logic number_next(input logic [7:0] b);
        return ident_next(b) || b == srctok_pkg::CH_DOT;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign o_cmd   = cmd;

    always_comb begin
        srctok_pkg::t_mode m;
        srctok_pkg::t_pos  pos;
        logic [srctok_pkg::COLUMN_BITS:0] col_sum;
        logic skip;
        m       = r_mode;
        pos     = '{line: r_line, col: r_col};
        col_sum = '0;
        skip    = 1'b0;
        n_mode  = r_mode;
        n_slash = r_slash;
        n_star  = r_star;
        n_line  = r_line;
        n_col   = r_col;
        n_held  = r_held;
        n_err   = r_err;
        n_fatal = r_fatal;
        cmd            = '0;
        cmd.hpos       = r_held;
        cmd.mpos       = r_held;
        cmd.spc_op     = srctok_pkg::SPC_NONE;
        cmd.main_kind  = srctok_pkg::KIND_PARAM;
        cmd.spc_byte   = i_byte;
        cmd.main_byte  = i_byte;
        if (i_end) begin
            cmd.slash     = r_slash;
            cmd.spc_op    = srctok_pkg::SPC_CLEAR;
            cmd.main_vld  = 1'b1;
            cmd.main_byte = 8'h00;
            cmd.main_kind = srctok_pkg::KIND_END;
            cmd.mpos      = pos;
            n_slash = 1'b0;
            n_star  = 1'b0;
            n_mode  = srctok_pkg::MODE_IDLE;
        end else begin
            // fall through modes that end on this byte
            case (m)
                srctok_pkg::MODE_IDENT:    if (!ident_next(i_byte)) m = srctok_pkg::MODE_IDLE;
                srctok_pkg::MODE_NUMBER:   if (!number_next(i_byte)) m = srctok_pkg::MODE_IDLE;
                srctok_pkg::MODE_DIR_NAME: if (!ident_next(i_byte)) m = srctok_pkg::MODE_DIR_LEAD;
                default: ;
            endcase
            if (m == srctok_pkg::MODE_DIR_LEAD && i_byte != srctok_pkg::CH_SP)
                m = srctok_pkg::MODE_DIR_PARAM;
            if (m == srctok_pkg::MODE_DIR_CONT && !is_white(i_byte))
                m = srctok_pkg::MODE_DIR_PARAM;
            n_mode = m;
            unique case (m)
                srctok_pkg::MODE_IDENT: begin
                    cmd.main_vld  = 1'b1;
                    cmd.main_kind = srctok_pkg::KIND_IDENT;
                end
                srctok_pkg::MODE_NUMBER: begin
                    cmd.main_vld  = 1'b1;
                    cmd.main_kind = srctok_pkg::KIND_NUMBER;
                end
                srctok_pkg::MODE_LINE_CMT: begin
                    if (i_byte == srctok_pkg::CH_NL) n_mode = srctok_pkg::MODE_IDLE;
                end
                srctok_pkg::MODE_BLOCK_CMT: begin
                    if (r_star && i_byte == srctok_pkg::CH_SLASH) begin
                        n_mode = srctok_pkg::MODE_IDLE;
                        n_star = 1'b0;
                    end else begin
                        n_star = (i_byte == srctok_pkg::CH_STAR);
                    end
                end
                srctok_pkg::MODE_DIR_NAME: begin
                    cmd.main_vld  = 1'b1;
                    cmd.main_kind = srctok_pkg::KIND_NAME;
                end
                srctok_pkg::MODE_DIR_LEAD: ;
                srctok_pkg::MODE_DIR_PARAM: begin
                    if (i_byte == srctok_pkg::CH_NL || i_byte == srctok_pkg::CH_CR) begin
                        cmd.spc_op = srctok_pkg::SPC_CLEAR;
                        n_mode     = srctok_pkg::MODE_IDLE;
                    end else if (i_byte == srctok_pkg::CH_BSL) begin
                        n_mode = srctok_pkg::MODE_DIR_BSLASH;
                    end else if (i_byte == srctok_pkg::CH_SP || i_byte == srctok_pkg::CH_TAB) begin
                        cmd.spc_op = srctok_pkg::SPC_PUSH;
                    end else begin
                        cmd.spc_op    = srctok_pkg::SPC_FLUSH;
                        cmd.main_vld  = 1'b1;
                        cmd.main_kind = srctok_pkg::KIND_PARAM;
                    end
                end
                srctok_pkg::MODE_DIR_BSLASH: begin
                    if (i_byte == srctok_pkg::CH_NL) begin
                        cmd.spc_op   = srctok_pkg::SPC_PUSH;
                        cmd.spc_byte = srctok_pkg::CH_SP;
                        n_mode       = srctok_pkg::MODE_DIR_CONT;
                    end else if (!is_white(i_byte)) begin
                        if (r_err != ERR_MAX) n_err = r_err + 1'b1;
                        if (n_err > {1'b0, r_max_err}) n_fatal = 1'b1;
                        cmd.main_vld  = 1'b1;
                        cmd.main_kind = srctok_pkg::KIND_PARAM;
                        cmd.main_err  = 1'b1;
                    end
                end
                srctok_pkg::MODE_DIR_CONT: ;
                default: begin
                    n_mode = srctok_pkg::MODE_IDLE;
                    if (r_slash) begin
                        n_slash = 1'b0;
                        if (i_byte == srctok_pkg::CH_SLASH) begin
                            n_mode = srctok_pkg::MODE_LINE_CMT;
                            skip   = 1'b1;
                        end else if (i_byte == srctok_pkg::CH_STAR) begin
                            n_mode = srctok_pkg::MODE_BLOCK_CMT;
                            n_star = 1'b0;
                            skip   = 1'b1;
                        end else begin
                            cmd.slash = 1'b1;
                        end
                    end
                    if (!skip && !is_white(i_byte)) begin
                        n_held = pos;
                        if (i_byte == srctok_pkg::CH_SLASH) begin
                            n_slash = 1'b1;
                        end else begin
                            cmd.main_vld   = 1'b1;
                            cmd.main_first = 1'b1;
                            cmd.mpos       = pos;
                            if (i_byte == srctok_pkg::CH_HASH) begin
                                cmd.main_kind = srctok_pkg::KIND_MARK;
                                cmd.spc_op    = srctok_pkg::SPC_CLEAR;
                                n_mode        = srctok_pkg::MODE_DIR_NAME;
                            end else if (ident_first(i_byte)) begin
                                cmd.main_kind = srctok_pkg::KIND_IDENT;
                                n_mode        = srctok_pkg::MODE_IDENT;
                            end else if (is_digit(i_byte) || i_byte == srctok_pkg::CH_DOT) begin
                                cmd.main_kind = srctok_pkg::KIND_NUMBER;
                                n_mode        = srctok_pkg::MODE_NUMBER;
                            end else begin
                                cmd.main_kind = srctok_pkg::KIND_SINGLE;
                            end
                        end
                    end
                end
            endcase
            // advance line and column
            if (i_byte == srctok_pkg::CH_NL) begin
                if (r_line != LINE_MAX) n_line = r_line + 1'b1;
                n_col = srctok_pkg::COLUMN_BITS'(1);
            end else begin
                col_sum = {1'b0, r_col} + ((i_byte == srctok_pkg::CH_TAB) ?
                          (srctok_pkg::COLUMN_BITS + 1)'(r_tab) :
                          (srctok_pkg::COLUMN_BITS + 1)'(1));
                n_col = col_sum[srctok_pkg::COLUMN_BITS] ? COL_MAX :
                        col_sum[srctok_pkg::COLUMN_BITS-1:0];
            end
        end
        cmd.fatal = n_fatal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err <= 8'd10;
            r_tab     <= 5'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == srctok_pkg::CFG_MAX_ERRORS) r_max_err <= i_cfg_data;
            if (i_cfg_addr == srctok_pkg::CFG_TAB_WIDTH)  r_tab     <= i_cfg_data[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= srctok_pkg::MODE_IDLE;
            r_slash <= 1'b0;
            r_star  <= 1'b0;
            r_line  <= srctok_pkg::LINE_BITS'(1);
            r_col   <= srctok_pkg::COLUMN_BITS'(1);
            r_err   <= '0;
            r_fatal <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_slash <= n_slash;
            r_star  <= n_star;
            r_line  <= n_line;
            r_col   <= n_col;
            r_err   <= n_err;
            r_fatal <= n_fatal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ----- rtl/srctok_back.sv -----
`timescale 1ns / 1ps

module srctok_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_vld,
    input  srctok_pkg::t_cmd                i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_byte,
    output srctok_pkg::t_kind               o_kind,
    output logic                            o_first,
    output logic [srctok_pkg::OUT_LINE_W-1:0] o_line,
    output logic [srctok_pkg::OUT_COL_W-1:0]  o_col,
    output logic                            o_err,
    output logic                            o_fatal,
    output logic                            o_last
);

    localparam logic [srctok_pkg::SPC_CNT_W-1:0] CNT_FULL =
        srctok_pkg::SPC_CNT_W'(srctok_pkg::SPACE_DEPTH);

    logic [7:0]                        r_buf [srctok_pkg::SPACE_DEPTH];
    logic [srctok_pkg::SPC_IDX_W-1:0]  r_head;
    logic [srctok_pkg::SPC_CNT_W-1:0]  r_cnt;
    srctok_pkg::t_phase                r_phase, n_phase;
    logic                              r_ovld;
    logic [7:0]                        r_obyte;
    srctok_pkg::t_kind                 r_okind;
    logic                              r_ofirst;
    srctok_pkg::t_pos                  r_opos;
    logic                              r_oerr, r_ofatal, r_olast;

    logic                              adv;
    logic                              emit;
    logic                              last;
    logic [7:0]                        e_byte;
    srctok_pkg::t_kind                 e_kind;
    logic                              e_first;
    srctok_pkg::t_pos                  e_pos;
    logic                              e_err;
    logic [srctok_pkg::SPC_CNT_W:0]    tail_sum;
    logic [srctok_pkg::SPC_IDX_W-1:0]  tail;
    logic [srctok_pkg::SPC_IDX_W-1:0]  head_inc;

    assign adv   = i_cmd_vld && (!r_ovld || i_ready);
    assign o_pop = adv && (r_phase == srctok_pkg::PH_MAIN);

    always_comb begin
        tail_sum = {1'b0, srctok_pkg::SPC_CNT_W'(r_head)} + {1'b0, r_cnt};
        if (tail_sum >= (srctok_pkg::SPC_CNT_W + 1)'(srctok_pkg::SPACE_DEPTH))
            tail_sum = tail_sum - (srctok_pkg::SPC_CNT_W + 1)'(srctok_pkg::SPACE_DEPTH);
        tail     = tail_sum[srctok_pkg::SPC_IDX_W-1:0];
        head_inc = (r_head == srctok_pkg::SPC_IDX_W'(srctok_pkg::SPACE_DEPTH - 1)) ?
                   '0 : r_head + 1'b1;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            srctok_pkg::PH_SLASH: n_phase = srctok_pkg::PH_BUF;
            srctok_pkg::PH_BUF: begin
                if (i_cmd.spc_op != srctok_pkg::SPC_FLUSH || r_cnt <= 1)
                    n_phase = srctok_pkg::PH_MAIN;
            end
            srctok_pkg::PH_MAIN:  n_phase = srctok_pkg::PH_SLASH;
            default:              n_phase = srctok_pkg::PH_SLASH;
        endcase
    end

    // result of the current phase
    always_comb begin
        emit    = 1'b0;
        last    = 1'b0;
        e_byte  = r_buf[r_head];
        e_kind  = srctok_pkg::KIND_PARAM;
        e_first = 1'b0;
        e_pos   = i_cmd.hpos;
        e_err   = 1'b0;
        unique case (r_phase)
            srctok_pkg::PH_SLASH: begin
                emit    = i_cmd.slash;
                last    = !i_cmd.main_vld;
                e_byte  = srctok_pkg::CH_SLASH;
                e_kind  = srctok_pkg::KIND_SINGLE;
                e_first = 1'b1;
            end
            srctok_pkg::PH_BUF: begin
                case (i_cmd.spc_op)
                    srctok_pkg::SPC_PUSH: begin
                        emit = (r_cnt == CNT_FULL);
                        last = !i_cmd.main_vld;
                    end
                    srctok_pkg::SPC_FLUSH: begin
                        emit = (r_cnt != '0);
                        last = (r_cnt == 1) && !i_cmd.main_vld;
                    end
                    default: ;
                endcase
            end
            srctok_pkg::PH_MAIN: begin
                emit    = i_cmd.main_vld;
                last    = 1'b1;
                e_byte  = i_cmd.main_byte;
                e_kind  = i_cmd.main_kind;
                e_first = i_cmd.main_first;
                e_pos   = i_cmd.mpos;
                e_err   = i_cmd.main_err;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srctok_pkg::PH_SLASH;
            r_cnt   <= '0;
            r_head  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (adv) begin
                r_phase <= n_phase;
                if (r_phase == srctok_pkg::PH_BUF) begin
                    case (i_cmd.spc_op)
                        srctok_pkg::SPC_PUSH: begin
                            if (r_cnt == CNT_FULL) r_head <= head_inc;
                            else                   r_cnt  <= r_cnt + 1'b1;
                        end
                        srctok_pkg::SPC_FLUSH: begin
                            if (r_cnt != '0) begin
                                r_head <= head_inc;
                                r_cnt  <= r_cnt - 1'b1;
                            end
                        end
                        srctok_pkg::SPC_CLEAR: r_cnt <= '0;
                        default: ;
                    endcase
                end
            end
            if (adv && emit) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_phase == srctok_pkg::PH_BUF && i_cmd.spc_op == srctok_pkg::SPC_PUSH) begin
            r_buf[tail] <= i_cmd.spc_byte;
        end
        if (adv && emit) begin
            r_obyte  <= e_byte;
            r_okind  <= e_kind;
            r_ofirst <= e_first;
            r_opos   <= e_pos;
            r_oerr   <= e_err;
            r_ofatal <= i_cmd.fatal;
            r_olast  <= last;
        end
    end

    assign o_valid = r_ovld;
    assign o_byte  = r_obyte;
    assign o_kind  = r_okind;
    assign o_first = r_ofirst;
    assign o_line  = srctok_pkg::OUT_LINE_W'(r_opos.line);
    assign o_col   = srctok_pkg::OUT_COL_W'(r_opos.col);
    assign o_err   = r_oerr;
    assign o_fatal = r_ofatal;
    assign o_last  = r_olast;

endmodule

// ----- rtl/source_tokenizer_with_comments.sv -----
`timescale 1ns / 1ps
// A byte's first result reaches the output register through the command queue and the
// back's phases: slash for a held slash, buffer for a flushed space, main for a token byte.
// Throughput: the front takes one byte a cycle while its 4-entry command queue has room;
// the back takes each item through the slash, buffer and main phases, repeating the buffer
// phase per space flushed beyond the first, and stalls while the output register is held.
// Reset (synchronous, active low) clears scan state, counters, queue and the space count;
// the space buffer holds stale bytes that are never read before being rewritten.
module source_tokenizer_with_comments (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [8] token_first, [32:9] start_line, [48:33] start_column,
    // [49] error_flag, [50] fatal_flag, [55:51] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // token_kind
    output logic        m_axis_tlast    // last_of_run
);

    srctok_pkg::t_cmd w_fcmd;
    srctok_pkg::t_cmd w_qcmd;
    logic w_push, w_pop, w_full, w_empty;
    logic [srctok_pkg::Q_CNT_W-1:0] w_qcnt;
    logic [7:0] w_byte;
    srctok_pkg::t_kind w_kind;
    logic w_first, w_err, w_fatal;
    logic [srctok_pkg::OUT_LINE_W-1:0] w_line;
    logic [srctok_pkg::OUT_COL_W-1:0] w_col;

    srctok_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_fcmd)
    );

    srctok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .i_pop   (w_pop),
        .o_cmd   (w_qcmd),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_qcnt)
    );

    srctok_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (!w_empty),
        .i_cmd     (w_qcmd),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (w_byte),
        .o_kind    (w_kind),
        .o_first   (w_first),
        .o_line    (w_line),
        .o_col     (w_col),
        .o_err     (w_err),
        .o_fatal   (w_fatal),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, w_fatal, w_err, w_col, w_line, w_first, w_byte};
    assign m_axis_tuser = w_kind;

    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qcnt <= srctok_pkg::Q_CNT_W'(srctok_pkg::QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_err_is_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_err) |-> (w_kind == srctok_pkg::KIND_PARAM && !w_first))
        else $error("error result not tagged as parameter");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_kind == srctok_pkg::KIND_END) |-> m_axis_tlast)
        else $error("end result not last of run");

    a_fatal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_fcmd.fatal) |=> (!w_push || w_fcmd.fatal))
        else $error("fatal state cleared");

endmodule
